// ----- rtl/core/lbp_pkg.sv -----
// lbp_pkg: shared types, command codes and helpers for the LSB-first bit packer.
// Depends on nothing; used by every module under rtl/core except lbp_ram.
package lbp_pkg;

  localparam int WORD_W = 32;
  localparam int TOT_W  = 16;
  localparam int WP_W   = 11;
  localparam int BP_W   = 5;
  localparam int CAP_W  = 11;

  localparam logic [2:0] CMD_WRITE  = 3'd0;
  localparam logic [2:0] CMD_PATCH  = 3'd1;
  localparam logic [2:0] CMD_ALIGN  = 3'd2;
  localparam logic [2:0] CMD_REWIND = 3'd3;
  localparam logic [2:0] CMD_FLUSH  = 3'd4;

  typedef struct packed {
    logic [2:0]  command;
    logic [31:0] value;
    logic [5:0]  bit_count;
    logic [14:0] bit_offset;
  } lbp_in_t;

  typedef struct packed {
    logic        word_write;
    logic [9:0]  word_addr;
    logic [31:0] word_data;
    logic [15:0] bits_written;
    logic [12:0] bytes_written;
    logic        overflowed;
    logic        cmd_error;
    logic        last;
  } lbp_out_t;

  // decoded command as it sits in the queue
  typedef struct packed {
    logic [2:0]  cmd;
    logic        bad_cnt;
    logic [5:0]  bits;
    logic [31:0] val;
    logic [14:0] offset;
    logic        span;
    logic [63:0] ins;
    logic [63:0] fmask;
  } lbp_op_t;

  typedef struct packed {
    logic              overflow;
    logic [TOT_W-1:0]  total;
    logic [BP_W-1:0]   bit_pos;
    logic [WP_W-1:0]   word_pos;
  } lbp_stat_t;

  function automatic logic [31:0] low_mask(input logic [BP_W-1:0] n);
    low_mask = (32'd1 << n) - 32'd1;
  endfunction

endpackage

// ----- rtl/core/lbp_ram.sv -----
// lbp_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
module lbp_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic                                  re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- rtl/core/lbp_front.sv -----
// lbp_front: decodes an incoming transaction into a queue entry (masks, shifts).
// Depends on lbp_pkg.
module lbp_front import lbp_pkg::*; (
  input  lbp_in_t in_item,
  output lbp_op_t op
);

  logic [63:0] field;
  logic [31:0] val;
  logic [4:0]  idx;

  always_comb begin
    field = (64'd1 << in_item.bit_count) - 64'd1;
    val   = in_item.value & field[31:0];
    idx   = in_item.bit_offset[4:0];

    op.cmd     = in_item.command;
    op.bad_cnt = (in_item.bit_count == 6'd0) || (in_item.bit_count > 6'd32);
    op.bits    = in_item.bit_count;
    op.val     = val;
    op.offset  = in_item.bit_offset;
    op.span    = ({2'b00, idx} + {1'b0, in_item.bit_count}) > 7'd32;
    op.ins     = {32'd0, val} << idx;
    op.fmask   = field << idx;
  end

endmodule

// ----- rtl/core/lbp_queue.sv -----
// lbp_queue: two-entry queue between the decode front and the execution back.
// Depends on lbp_pkg.
module lbp_queue import lbp_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  lbp_op_t push_op,
  input  logic    pop,
  output logic    not_empty,
  output logic    full,
  output lbp_op_t head
);

  lbp_op_t    ent_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wr_ptr_r] <= push_op;
    end
  end

  assign not_empty = cnt_r != 2'd0;
  assign full      = cnt_r == 2'd2;
  assign head      = ent_r[rd_ptr_r];

endmodule

// ----- rtl/core/lbp_back.sv -----
// lbp_back: executes queued commands against the accumulator and word store,
// and holds the result register. Depends on lbp_pkg and lbp_ram.
module lbp_back import lbp_pkg::*; #(
  parameter int STORE_WORDS = 1024
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic [CAP_W-1:0] cap_words,
  input  logic             q_valid,
  input  lbp_op_t          q_head,
  output logic             q_pop,
  output logic             out_valid,
  input  logic             out_stall,
  output lbp_out_t         out_data,
  output lbp_stat_t        stat
);

  localparam int AW = STORE_WORDS > 1 ? $clog2(STORE_WORDS) : 1;

  localparam logic [1:0] S_EXEC = 2'd0;
  localparam logic [1:0] S_RD1  = 2'd1;
  localparam logic [1:0] S_RD2  = 2'd2;
  localparam logic [1:0] S_RDR  = 2'd3;

  logic [1:0]        state_r, state_nxt;
  logic [31:0]       acc_r, acc_nxt;
  logic [BP_W-1:0]   bp_r, bp_nxt;
  logic [WP_W-1:0]   wp_r, wp_nxt;
  logic [TOT_W-1:0]  tot_r, tot_nxt;
  logic              ovf_r, ovf_nxt;
  logic              out_valid_r, out_valid_nxt;
  lbp_out_t          out_data_r, out_data_nxt;

  logic              slot, emit, ww, err, last;
  logic [WP_W-1:0]   waddr, rd_addr, w11, w11p;
  logic [31:0]       wdata, rdata;
  logic              rd_en, ram_we;
  logic [CAP_W-1:0]  cap_eff;
  logic [TOT_W-1:0]  cap_bits;
  logic [31:0]       app_v;
  logic [5:0]        app_n, align_n, bsum;
  logic [16:0]       sum_tot;
  logic              app_ovf;
  logic [63:0]       shifted;
  logic [31:0]       acc_or;
  logic              patch_bad, rew_bad, rew_near;
  logic [TOT_W-1:0]  rew_tot;
  logic [12:0]       bytes;

  lbp_ram #(.WIDTH(WORD_W), .DEPTH(STORE_WORDS)) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (AW'(waddr)),
    .wdata (wdata),
    .re    (rd_en),
    .raddr (AW'(rd_addr)),
    .rdata (rdata)
  );

  always_comb begin
    slot     = !out_valid_r || !out_stall;
    cap_eff  = ({21'd0, cap_words} > 32'(STORE_WORDS)) ? CAP_W'(STORE_WORDS) : cap_words;
    cap_bits = {cap_eff, 5'd0};
    w11      = {1'b0, q_head.offset[14:5]};
    w11p     = w11 + 11'd1;
    align_n  = 6'd8 - {3'd0, tot_r[2:0]};
    app_v    = (q_head.cmd == CMD_ALIGN) ? 32'd0 : q_head.val;
    app_n    = (q_head.cmd == CMD_ALIGN) ? align_n : q_head.bits;
    sum_tot  = {1'b0, tot_r} + {11'd0, app_n};
    app_ovf  = sum_tot > {1'b0, cap_bits};
    shifted  = {32'd0, app_v} << bp_r;
    acc_or   = acc_r | shifted[31:0];
    bsum     = {1'b0, bp_r} + app_n;
    patch_bad = q_head.bad_cnt ||
                (({2'b00, q_head.offset} + {11'd0, q_head.bits}) > {1'b0, tot_r});
    rew_bad  = (q_head.bits == 6'd0) || ({10'd0, q_head.bits} > tot_r);
    rew_tot  = tot_r - TOT_W'(q_head.bits);
    rew_near = q_head.bits <= {1'b0, bp_r};
  end

  always_comb begin
    state_nxt = state_r;
    acc_nxt   = acc_r;
    bp_nxt    = bp_r;
    wp_nxt    = wp_r;
    tot_nxt   = tot_r;
    ovf_nxt   = ovf_r;
    emit      = 1'b0;
    ww        = 1'b0;
    waddr     = wp_r;
    wdata     = 32'd0;
    err       = 1'b0;
    last      = 1'b1;
    q_pop     = 1'b0;
    rd_en     = 1'b0;
    rd_addr   = w11;

    unique case (state_r)
      S_EXEC: begin
        if (q_valid) begin
          unique case (q_head.cmd)
            CMD_WRITE, CMD_ALIGN: begin
              if (slot) begin
                emit  = 1'b1;
                q_pop = 1'b1;
                if (q_head.cmd == CMD_WRITE && q_head.bad_cnt) begin
                  err = 1'b1;
                end else if (q_head.cmd == CMD_WRITE || tot_r[2:0] != 3'd0) begin
                  if (app_ovf) begin
                    ovf_nxt = 1'b1;
                  end else begin
                    tot_nxt = sum_tot[TOT_W-1:0];
                    bp_nxt  = bsum[BP_W-1:0];
                    if (bsum[5]) begin
                      ww      = 1'b1;
                      waddr   = wp_r;
                      wdata   = acc_or;
                      wp_nxt  = wp_r + 11'd1;
                      acc_nxt = shifted[63:32];
                    end else begin
                      acc_nxt = acc_or;
                    end
                  end
                end
              end
            end
            CMD_FLUSH: begin
              if (slot) begin
                emit  = 1'b1;
                q_pop = 1'b1;
                if (bp_r != 5'd0 && tot_r < cap_bits) begin
                  ww    = 1'b1;
                  waddr = wp_r;
                  wdata = acc_r;
                end
              end
            end
            CMD_REWIND: begin
              if (rew_bad || rew_near) begin
                if (slot) begin
                  emit  = 1'b1;
                  q_pop = 1'b1;
                  if (rew_bad) begin
                    err = 1'b1;
                  end else begin
                    tot_nxt = rew_tot;
                    bp_nxt  = bp_r - q_head.bits[BP_W-1:0];
                    acc_nxt = acc_r & low_mask(bp_nxt);
                  end
                end
              end else begin
                rd_en     = 1'b1;
                rd_addr   = rew_tot[15:5];
                state_nxt = S_RDR;
              end
            end
            CMD_PATCH: begin
              if (patch_bad || w11 == wp_r) begin
                if (slot) begin
                  emit  = 1'b1;
                  q_pop = 1'b1;
                  if (patch_bad) begin
                    err = 1'b1;
                  end else begin
                    acc_nxt = (acc_r & ~q_head.fmask[31:0]) | q_head.ins[31:0];
                  end
                end
              end else begin
                rd_en     = 1'b1;
                rd_addr   = w11;
                state_nxt = S_RD1;
              end
            end
            default: begin
              if (slot) begin
                emit  = 1'b1;
                q_pop = 1'b1;
                err   = 1'b1;
              end
            end
          endcase
        end
      end
      S_RD1: begin
        if (slot) begin
          emit  = 1'b1;
          ww    = 1'b1;
          waddr = w11;
          wdata = (rdata & ~q_head.fmask[31:0]) | q_head.ins[31:0];
          priority if (!q_head.span) begin
            q_pop     = 1'b1;
            state_nxt = S_EXEC;
          end else if (w11p == wp_r) begin
            acc_nxt   = (acc_r & ~q_head.fmask[63:32]) | q_head.ins[63:32];
            q_pop     = 1'b1;
            state_nxt = S_EXEC;
          end else begin
            last      = 1'b0;
            rd_en     = 1'b1;
            rd_addr   = w11p;
            state_nxt = S_RD2;
          end
        end
      end
      S_RD2: begin
        if (slot) begin
          emit      = 1'b1;
          ww        = 1'b1;
          waddr     = w11p;
          wdata     = (rdata & ~q_head.fmask[63:32]) | q_head.ins[63:32];
          q_pop     = 1'b1;
          state_nxt = S_EXEC;
        end
      end
      S_RDR: begin
        if (slot) begin
          emit      = 1'b1;
          q_pop     = 1'b1;
          tot_nxt   = rew_tot;
          bp_nxt    = rew_tot[4:0];
          wp_nxt    = rew_tot[15:5];
          acc_nxt   = rdata & low_mask(rew_tot[4:0]);
          state_nxt = S_EXEC;
        end
      end
      default: state_nxt = S_EXEC;
    endcase

    ram_we = emit && ww && ({21'd0, waddr} < 32'(STORE_WORDS));
    bytes  = 13'({wp_nxt, 2'b00}) + 13'(bp_nxt[4:3]) + 13'(|bp_nxt[2:0]);

    out_data_nxt.word_write    = ww;
    out_data_nxt.word_addr     = ww ? waddr[9:0] : 10'd0;
    out_data_nxt.word_data     = wdata;
    out_data_nxt.bits_written  = tot_nxt;
    out_data_nxt.bytes_written = bytes;
    out_data_nxt.overflowed    = ovf_nxt;
    out_data_nxt.cmd_error     = err;
    out_data_nxt.last          = last;

    out_valid_nxt = emit ? 1'b1 : (out_valid_r && out_stall);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_EXEC;
      acc_r       <= 32'd0;
      bp_r        <= '0;
      wp_r        <= '0;
      tot_r       <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      acc_r       <= acc_nxt;
      bp_r        <= bp_nxt;
      wp_r        <= wp_nxt;
      tot_r       <= tot_nxt;
      ovf_r       <= ovf_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_data      = out_data_r;
  assign stat.overflow = ovf_r;
  assign stat.total    = tot_r;
  assign stat.bit_pos  = bp_r;
  assign stat.word_pos = wp_r;

endmodule

// ----- rtl/core/lsb_first_bit_packer.sv -----
// lsb_first_bit_packer: top level. A transaction is accepted into the queue, executed
// from its head and its result registered; a patch or long rewind first reads the word store.
// Throughput: 1 transaction per cycle for write, align, flush and short rewind while the
// receiver does not stall; a store patch or a rewind past the current word first reads the
// store, and a patch spanning two stored words reads both. Set by the single store read port.
// Reset: synchronous active-low rst_n clears all control state and the packer
// state; capacity returns to 1024 words; store contents are left undefined.
module lsb_first_bit_packer import lbp_pkg::*; #(
  parameter int STORE_WORDS = 1024
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  lbp_in_t          in_data,
  output logic             out_valid,
  input  logic             out_stall,
  output lbp_out_t         out_data,
  input  logic             cfg_we,
  input  logic [CAP_W-1:0] cfg_wdata
);

  // capacity register; it is to be written only while idle, which the block itself does not enforce
  logic [CAP_W-1:0] cap_r;

  lbp_op_t   dec_op;
  lbp_op_t   q_head;
  logic      q_push, q_pop, q_valid, q_full;
  lbp_stat_t stat;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= 11'd1024;
    end else if (cfg_we) begin
      cap_r <= cfg_wdata;
    end
  end

  // front: decode every transaction into shifted field and mask
  lbp_front u_front (
    .in_item (in_data),
    .op      (dec_op)
  );

  // a full queue is the only input backpressure
  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full;

  lbp_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_op   (dec_op),
    .pop       (q_pop),
    .not_empty (q_valid),
    .full      (q_full),
    .head      (q_head)
  );

  // back: accumulator, store read-modify-write, result register
  lbp_back #(.STORE_WORDS(STORE_WORDS)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cap_words (cap_r),
    .q_valid   (q_valid),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .stat      (stat)
  );

  // overflow flag is sticky
  a_ovf_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    stat.overflow |=> stat.overflow)
    else $error("overflow flag cleared");

  // bit count always matches word and bit position
  a_pos_consistent: assert property (@(posedge clk) disable iff (!rst_n)
    stat.total == {stat.word_pos, stat.bit_pos})
    else $error("bit count out of step with position");

  // nothing pops an empty queue
  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_valid)
    else $error("queue popped while empty");

endmodule

// ----- tb/sv/tb_lsb_first_bit_packer.sv -----
// Testbench for lsb_first_bit_packer: directed and random write, patch, align,
// rewind and flush transactions checked against an in-bench packer model.
// Depends on lbp_pkg and the lsb_first_bit_packer RTL.
`timescale 1ns / 1ps

module tb_lsb_first_bit_packer;
  import lbp_pkg::*;

  // Reference packer plus the queue of results it predicts
  class packer_scoreboard;
    logic [31:0] words [0:1023];
    logic [31:0] acc;
    int unsigned bit_pos, word_pos, total, cap_words;
    bit ovf;
    lbp_out_t pending [$];
    int errors;
    lbp_out_t evs [$];

    function void clear();
      acc = 0; bit_pos = 0; word_pos = 0; total = 0; ovf = 0;
      cap_words = 1024; errors = 0; pending.delete();
      for (int i = 0; i < 1024; i++) words[i] = 0;
    endfunction

    function int unsigned cap_bits();
      return (cap_words > 1024 ? 1024 : cap_words) * 32;
    endfunction

    function void store(int unsigned a, logic [31:0] d);
      lbp_out_t e;
      if (a < 1024) words[a] = d;
      e = '0; e.word_write = 1; e.word_addr = a[9:0]; e.word_data = d;
      if (evs.size() < 2) evs.push_back(e);
    endfunction

    function void append(logic [31:0] v, int unsigned n);
      logic [63:0] sh;
      if (total + n > cap_bits()) begin
        ovf = 1;
        return;
      end
      if (n < 32) v = v & ((32'd1 << n) - 1);
      total += n;
      sh = {32'd0, v} << bit_pos;
      acc |= sh[31:0];
      if (bit_pos + n <= 32) begin
        bit_pos += n;
        if (bit_pos == 32) begin
          store(word_pos, acc);
          word_pos++; bit_pos = 0; acc = 0;
        end
      end else begin
        store(word_pos, acc);
        word_pos++;
        acc = v >> (32 - bit_pos);
        bit_pos = n - (32 - bit_pos);
      end
    endfunction

    function void merge(int unsigned w, logic [31:0] keep, logic [31:0] ins);
      if (w == word_pos) acc = (acc & keep) | ins;
      else store(w, ((w < 1024 ? words[w] : 32'd0) & keep) | ins);
    endfunction

    // Accepted input: compute its one or two expected results
    function void note_input(lbp_in_t t);
      logic [63:0] fld, ins, keep;
      int unsigned n, off, w, i, bytes, cnt;
      bit err;
      lbp_out_t r;
      evs.delete(); err = 0;
      n = t.bit_count; off = t.bit_offset;
      case (t.command)
        CMD_WRITE: if (n == 0 || n > 32) err = 1; else append(t.value, n);
        CMD_PATCH:
          if (n == 0 || n > 32 || off + n > total) err = 1;
          else begin
            w = off / 32; i = off % 32;
            fld = (64'd1 << n) - 1;
            ins = ({32'd0, t.value} & fld) << i;
            keep = ~(fld << i);
            merge(w, keep[31:0], ins[31:0]);
            if (i + n > 32) merge(w + 1, keep[63:32], ins[63:32]);
          end
        CMD_ALIGN: if (total % 8 != 0) append(0, 8 - total % 8);
        CMD_REWIND:
          if (n == 0 || n > total) err = 1;
          else begin
            total -= n;
            if (n <= bit_pos) bit_pos -= n;
            else begin
              bit_pos = total % 32; word_pos = total / 32;
              acc = word_pos < 1024 ? words[word_pos] : 32'd0;
            end
            acc &= ((32'd1 << bit_pos) - 32'd1);
          end
        CMD_FLUSH: if (bit_pos != 0 && total < cap_bits()) store(word_pos, acc);
        default: err = 1;
      endcase
      bytes = word_pos * 4 + (bit_pos + 7) / 8;
      cnt = evs.size() > 0 ? evs.size() : 1;
      for (int k = 0; k < cnt; k++) begin
        r = evs.size() > 0 ? evs[k] : '0;
        r.bits_written = total[15:0];
        r.bytes_written = bytes[12:0];
        r.overflowed = ovf;
        r.cmd_error = err;
        r.last = (k == cnt - 1);
        pending.push_back(r);
      end
    endfunction

    function void check_result(lbp_out_t got);
      lbp_out_t e;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result %h", $time, got);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (got !== e) begin
        $display("%0t: mismatch expected %h actual %h", $time, e, got);
        errors++;
      end
    endfunction
  endclass

  logic clk = 0, rst_n = 0;
  logic in_valid = 0, in_stall, out_valid, out_stall = 0;
  lbp_in_t in_data = '0;
  lbp_out_t out_data;
  logic cfg_we = 0;
  logic [CAP_W-1:0] cfg_wdata = '0;
  packer_scoreboard sb;
  int sent;
  bit rx_hold;  // when set, the receiver never stalls

  lsb_first_bit_packer uut (.*);

  always #5 clk = ~clk;

  initial begin
    #20ms;
    $display("FAILED: results differ");
    $finish;
  end

  // mostly short gaps, now and then a long one
  function automatic int gap_len();
    int p = $urandom_range(0, 99);
    if (p < 55) return 0;
    if (p < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Receiver: random stall, sample on the rising edge
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_result(out_data);
  end
  always @(negedge clk) begin
    out_stall <= rx_hold ? 1'b0 : ($urandom_range(0, 99) < 25);
  end

  // Drive one transaction and wait for its acceptance; valid stays high
  // until the next falling edge, where the next send or drain takes over
  task automatic send(lbp_in_t t);
    int g = gap_len();
    @(negedge clk);
    if (g > 0) begin
      in_valid <= 0;
      repeat (g) @(negedge clk);
    end
    in_data <= t;
    in_valid <= 1;
    do @(posedge clk); while (in_stall);
    sb.note_input(t);
    sent++;
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid <= 0;
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic set_capacity(logic [CAP_W-1:0] c);
    drain();
    @(negedge clk);
    cfg_we <= 1; cfg_wdata <= c;
    @(negedge clk);
    cfg_we <= 0;
    sb.cap_words = c;
  endtask

  function automatic lbp_in_t mk(logic [2:0] c, logic [31:0] v, int n, int off);
    lbp_in_t t;
    t.command = c; t.value = v; t.bit_count = n[5:0]; t.bit_offset = off[14:0];
    return t;
  endfunction

  // Mostly legal commands with random content; a share of malformed ones
  function automatic lbp_in_t rand_item();
    int p = $urandom_range(0, 99);
    int tot = sb.total;
    int n = $urandom_range(1, 32);
    if (p < 45) return mk(CMD_WRITE, $urandom, n, $urandom_range(0, 32767));
    if (p < 62 && tot > 0) begin
      if (n > tot) n = tot;
      return mk(CMD_PATCH, $urandom, n, $urandom_range(0, tot - n));
    end
    if (p < 70) return mk(CMD_ALIGN, $urandom, $urandom_range(0, 63), $urandom);
    if (p < 80 && tot > 0)
      return mk(CMD_REWIND, $urandom, $urandom_range(1, tot < 63 ? tot : 63), $urandom);
    if (p < 86) return mk(CMD_FLUSH, $urandom, $urandom_range(0, 63), $urandom);
    // noise: bad counts, bad offsets, unknown codes
    return mk($urandom_range(0, 7), $urandom, $urandom_range(0, 63), $urandom_range(0, 32767));
  endfunction

  initial begin
    int caps [5] = '{1024, 1, 3, 2047, 0};
    sb = new();
    sb.clear();
    sent = 0; rx_hold = 0;
    repeat (8) @(negedge clk);
    rst_n <= 1;
    @(negedge clk);

    // Directed: extremes, every command and each corner case
    send(mk(CMD_WRITE, 32'hFFFF_FFFF, 32, 0));
    send(mk(CMD_WRITE, 32'hFFFF_FFFF, 1, 0));
    send(mk(CMD_WRITE, 32'hA5A5_A5A5, 0, 0));   // bad count
    send(mk(CMD_WRITE, 32'h1234_5678, 33, 0));  // bad count
    send(mk(CMD_WRITE, 32'hDEAD_BEEF, 31, 0));  // fills the word exactly
    send(mk(CMD_PATCH, 32'h0, 32, 0));
    send(mk(CMD_PATCH, 32'hFFFF_FFFF, 20, 20)); // spans two words
    send(mk(CMD_PATCH, 32'h3, 2, 62));          // into the last stored word
    send(mk(CMD_PATCH, 32'h1, 1, 32767));       // offset past end
    send(mk(CMD_ALIGN, 0, 0, 0));
    send(mk(CMD_ALIGN, 0, 0, 0));
    send(mk(CMD_FLUSH, 0, 0, 0));
    send(mk(CMD_REWIND, 0, 40, 0));             // past the current word
    send(mk(CMD_REWIND, 0, 0, 0));              // bad count
    send(mk(CMD_REWIND, 0, 63, 0));             // above total
    send(mk(3'd5, 0, 1, 0));
    send(mk(3'd7, 32'hFFFF_FFFF, 63, 32767));
    send(mk(CMD_FLUSH, 0, 0, 0));

    // Capacity phases: tiny, zero and oversized ones included
    foreach (caps[c]) begin
      set_capacity(caps[c][CAP_W-1:0]);
      send(mk(CMD_WRITE, 32'hFFFF_FFFF, 32, 0));
      send(mk(CMD_WRITE, 32'h5, 3, 0));
      send(mk(CMD_ALIGN, 0, 0, 0));
      send(mk(CMD_FLUSH, 0, 0, 0));
      for (int i = 0; i < 40; i++) send(rand_item());
    end

    // Back to full capacity for the bulk, with a mid-run pause
    set_capacity(11'd1024);
    for (int i = 0; i < 1000; i++) begin
      // keep the store from filling so writes stay meaningful
      if (sb.total > 30000) send(mk(CMD_REWIND, 0, 63, 0));
      else send(rand_item());
      if (i == 500) begin
        drain();
        rx_hold = 1;
      end
      if (i == 700) rx_hold = 0;
    end

    drain();
    $display("Ran %0d transactions over capacities 0, 1, 3, 1024 and 2047,", sent);
    $display("covering all commands, malformed ones and overflow.");
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/core/lbp_pkg.sv
rtl/core/lbp_ram.sv
rtl/core/lbp_front.sv
rtl/core/lbp_queue.sv
rtl/core/lbp_back.sv
rtl/core/lsb_first_bit_packer.sv
tb/sv/tb_lsb_first_bit_packer.sv
